@@ src/lru_key_value_cache_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LRUKV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lrukv assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LRUKV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lrukv assertion failed");

`endif

@@ src/lrukv_pkg.sv @@
package lrukv_pkg;

	// field widths fixed by the access format
	localparam int unsigned KEY_W = 32;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CAP_W = 5;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// value returned by a get that misses
	localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

	// value returned by every put
	localparam logic signed [VAL_W-1:0] PUT_VALUE = 32'sd0;

	// access opcodes
	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	// lookup outcome from the tag array to the value store
	typedef struct packed {
		logic hit;
		logic val_we;
		logic val_re;
	} access_t;

endpackage

@@ src/lrukv_req_if.sv @@
interface lrukv_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  opcode;
	logic signed [lrukv_pkg::KEY_W-1:0]    lookup_key;
	logic signed [lrukv_pkg::VAL_W-1:0]    write_value;

	modport source (output valid, opcode, lookup_key, write_value, input ready);
	modport sink (input valid, opcode, lookup_key, write_value, output ready);
endinterface

@@ src/lrukv_rsp_if.sv @@
interface lrukv_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  hit;
	logic signed [lrukv_pkg::VAL_W-1:0]    read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink (input valid, hit, read_value, output ready);
endinterface

@@ src/lrukv_ram.sv @@
module lrukv_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/lrukv_tag_array.sv @@
module lrukv_tag_array #(
	parameter int unsigned ENTRIES = 16,
	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             proc,
	input  lrukv_pkg::op_t                   op,
	input  logic [lrukv_pkg::KEY_W-1:0]      key,
	input  logic [lrukv_pkg::CAP_W-1:0]      cap,
	output lrukv_pkg::access_t               acc,
	output logic [IW-1:0]                    slot
);

	localparam int unsigned CW   = $clog2(ENTRIES + 1);
	localparam int unsigned CMPW = (CW > lrukv_pkg::CAP_W) ? CW : lrukv_pkg::CAP_W;

	logic [lrukv_pkg::KEY_W-1:0] key_q   [ENTRIES];
	logic [IW-1:0]               rank_q  [ENTRIES];
	logic [ENTRIES-1:0]          valid_q;
	logic [CW-1:0]               count_q;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] victim;
	logic [ENTRIES-1:0] valid_after;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] free_oh;
	logic [IW-1:0]      hit_idx;
	logic [IW-1:0]      hit_rank;
	logic [IW-1:0]      free_idx;
	logic [IW-1:0]      oldest_rank;
	logic [CMPW-1:0]    eff_cap;
	logic               hit;
	logic               have_free;
	logic               full;

	// effective capacity: zero acts as one, saturate at the slot count
	always_comb begin
		eff_cap = CMPW'(cap);
		if (cap == '0) begin
			eff_cap = CMPW'(1);
		end else if (CMPW'(cap) > CMPW'(ENTRIES)) begin
			eff_cap = CMPW'(ENTRIES);
		end
	end

	assign full        = CMPW'(count_q) >= eff_cap;
	assign oldest_rank = IW'(count_q - CW'(1));

	// parallel key compare and oldest-entry match
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == key);
			victim[i] = valid_q[i] && full && (rank_q[i] == oldest_rank);
		end
	end

	assign hit         = |match;
	assign valid_after = valid_q & ~victim;
	assign free_vec    = ~valid_after;
	assign free_oh     = free_vec & (~free_vec + ENTRIES'(1));
	assign have_free   = |free_vec;

	// one-hot to index for the hit slot and the free slot
	always_comb begin
		hit_idx  = '0;
		hit_rank = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_idx  = hit_idx | IW'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (free_oh[i]) begin
				free_idx = free_idx | IW'(i);
			end
		end
	end

	// lookup outcome for the value store
	always_comb begin
		acc.hit    = hit;
		acc.val_we = proc && (op == lrukv_pkg::OP_PUT) && (hit || have_free);
		acc.val_re = proc && (op == lrukv_pkg::OP_GET) && hit;
		slot       = hit ? hit_idx : free_idx;
	end

	// valid bits, age ranks and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (proc) begin
			if (hit) begin
				// promote: younger entries age by one
				for (int i = 0; i < ENTRIES; i++) begin
					if (match[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
			end else if (op == lrukv_pkg::OP_PUT) begin
				// evict oldest if full, insert in lowest free slot
				for (int i = 0; i < ENTRIES; i++) begin
					if (free_oh[i]) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (victim[i]) begin
						valid_q[i] <= 1'b0;
						rank_q[i]  <= '0;
					end else if (valid_after[i]) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				if (!full && have_free) begin
					count_q <= count_q + CW'(1);
				end else if (full && !have_free) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// key storage, written on insert only
	always_ff @(posedge clk) begin
		if (proc && !hit && (op == lrukv_pkg::OP_PUT)) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (free_oh[i]) begin
					key_q[i] <= key;
				end
			end
		end
	end

endmodule

@@ src/lru_key_value_cache_unit.sv @@
// channel  dir  payload                               transfer
// req      in   opcode, lookup_key, write_value       req.valid && req.ready
// rsp      out  hit, read_value                       rsp.valid && rsp.ready
// cfg      in   cfg_wdata (capacity_in_use)           cfg_we
//
// one access per cycle sustained while the result side does not stall; the result is
// registered through the input register, then lookup/update into the result register
// tag compare, age update and value write all complete in the processing cycle
// arst_n clears the store to empty and capacity to 16; no clearing pass
// a stalled result holds the input register; req.ready drops only then
module lru_key_value_cache_unit #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lrukv_pkg::CAP_W-1:0]   cfg_wdata,
	lrukv_req_if.sink                     req,
	lrukv_rsp_if.source                   rsp
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [lrukv_pkg::CAP_W-1:0]  cap_q;
	logic                         vld_s1;
	lrukv_pkg::op_t               op_s1;
	logic [lrukv_pkg::KEY_W-1:0]  key_s1;
	logic [lrukv_pkg::VAL_W-1:0]  val_s1;
	logic                         vld_s2;
	logic                         hit_s2;
	lrukv_pkg::op_t               op_s2;
	logic [lrukv_pkg::VAL_W-1:0]  rdata_s2;
	logic                         proc;
	lrukv_pkg::access_t           acc;
	logic [IW-1:0]                slot;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lrukv_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// the item in the input register is processed when the result slot frees
	assign proc      = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || proc;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1  <= lrukv_pkg::op_t'(req.opcode);
			key_s1 <= req.lookup_key;
			val_s1 <= req.write_value;
		end
	end

	// keys, valid bits and age ranks
	lrukv_tag_array #(
		.ENTRIES (ENTRIES)
	) u_tag (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (proc),
		.op     (op_s1),
		.key    (key_s1),
		.cap    (cap_q),
		.acc    (acc),
		.slot   (slot)
	);

	// value store, read data lands with the result register
	lrukv_ram #(
		.WIDTH (lrukv_pkg::VAL_W),
		.DEPTH (ENTRIES)
	) u_val (
		.clk   (clk),
		.we    (acc.val_we),
		.waddr (slot),
		.wdata (val_s1),
		.re    (acc.val_re),
		.raddr (slot),
		.rdata (rdata_s2)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || rsp.ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			hit_s2 <= acc.hit;
			op_s2  <= op_s1;
		end
	end

	// result select
	always_comb begin
		rsp.valid = vld_s2;
		rsp.hit   = hit_s2;
		if (op_s2 == lrukv_pkg::OP_PUT) begin
			rsp.read_value = lrukv_pkg::PUT_VALUE;
		end else if (hit_s2) begin
			rsp.read_value = rdata_s2;
		end else begin
			rsp.read_value = lrukv_pkg::MISS_VALUE;
		end
	end

endmodule

@@ src/lrukv_checker.sv @@
`include "lru_key_value_cache_unit_assert.svh"

module lrukv_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic                                rsp_hit,
	input logic signed [lrukv_pkg::VAL_W-1:0]  rsp_read_value
);

	// a stalled result holds
	`LRUKV_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))

	// an empty result slot never blocks requests
	`LRUKV_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !rsp_valid, req_ready)

	// a result transfer always makes room for a request
	`LRUKV_ASSERT_IMP(a_ready_on_drain, clk, arst_n, rsp_valid && rsp_ready, req_ready)

	// a miss returns only the put or the miss value
	`LRUKV_ASSERT_IMP(a_miss_value, clk, arst_n, rsp_valid && !rsp_hit, (rsp_read_value == lrukv_pkg::PUT_VALUE) || (rsp_read_value == lrukv_pkg::MISS_VALUE))

endmodule

bind lru_key_value_cache_unit lrukv_checker u_lrukv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_read_value (rsp.read_value)
);

@@ sim/lru_cache_checker.sv @@
module lru_cache_checker #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lrukv_pkg::CAP_W-1:0]   cfg_wdata,
	lrukv_req_if                          req,
	lrukv_rsp_if                          rsp,
	output int                            mismatch_count,
	output int                            pending
);
	import lrukv_pkg::*;

	typedef struct packed {
		logic                     hit;
		logic signed [VAL_W-1:0]  value;
	} access_result_t;

	// shadow copy of the store
	logic signed [KEY_W-1:0] slot_key [ENTRIES];
	logic signed [VAL_W-1:0] slot_val [ENTRIES];
	bit                      slot_used [ENTRIES];
	int unsigned             slot_age [ENTRIES];
	int unsigned             used_count;
	logic [CAP_W-1:0]        capacity;

	access_result_t expected_results [$];
	access_result_t oldest, predicted;
	int             results_seen;

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		mismatch_count++;
	endtask

	// one access against the shadow store, updating it as the block would
	function automatic void predict_access(
		input  op_t                     op,
		input  logic signed [KEY_W-1:0] key,
		input  logic signed [VAL_W-1:0] value,
		output logic                    hit,
		output logic signed [VAL_W-1:0] result
	);
		int i, found, victim, free_slot;
		int unsigned age, limit;
		found = -1;
		victim = -1;
		free_slot = -1;
		age = 0;
		for (i = 0; i < ENTRIES; i++) begin
			if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
		end
		hit = (found >= 0);
		result = (op == OP_GET) ? MISS_VALUE : PUT_VALUE;
		if (found >= 0) begin
			if (op == OP_GET) result = slot_val[found];
			else slot_val[found] = value;
			// promote to most recent
			age = slot_age[found];
			for (i = 0; i < ENTRIES; i++) begin
				if (slot_used[i] && slot_age[i] < age) slot_age[i]++;
			end
			slot_age[found] = 0;
		end else if (op == OP_PUT) begin
			limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
			// evict the oldest entry, ties go to the highest slot
			if (used_count >= limit) begin
				for (i = 0; i < ENTRIES; i++) begin
					if (slot_used[i] && (victim < 0 || slot_age[i] >= age)) begin
						victim = i;
						age = slot_age[i];
					end
				end
				if (victim >= 0) begin
					slot_used[victim] = 1'b0;
					slot_age[victim] = 0;
					if (used_count > 0) used_count--;
				end
			end
			// insert into the lowest free slot as most recent
			for (i = 0; i < ENTRIES; i++) begin
				if (!slot_used[i] && free_slot < 0) free_slot = i;
			end
			if (free_slot >= 0) begin
				for (i = 0; i < ENTRIES; i++) begin
					if (slot_used[i]) slot_age[i]++;
				end
				slot_key[free_slot] = key;
				slot_val[free_slot] = value;
				slot_used[free_slot] = 1'b1;
				slot_age[free_slot] = 0;
				used_count++;
			end
		end
	endfunction

	// watch config, request and result transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_key[i] = '0;
				slot_val[i] = '0;
				slot_used[i] = 1'b0;
				slot_age[i] = 0;
			end
			used_count = 0;
			capacity = CAP_RESET;
			expected_results.delete();
			results_seen = 0;
			mismatch_count = 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result hit=%0b value=%0d",
						rsp.hit, rsp.read_value));
				end else begin
					oldest = expected_results.pop_front();
					if (rsp.hit !== oldest.hit)
						report_mismatch($sformatf("hit %0b, want %0b", rsp.hit, oldest.hit));
					if (rsp.read_value !== oldest.value)
						report_mismatch($sformatf("read_value %0d, want %0d",
							rsp.read_value, oldest.value));
				end
				results_seen++;
			end
			if (cfg_we) capacity = cfg_wdata;
			if (req.valid && req.ready) begin
				predict_access(op_t'(req.opcode), req.lookup_key, req.write_value,
					predicted.hit, predicted.value);
				expected_results.push_back(predicted);
			end
			pending <= expected_results.size();
		end
	end

endmodule

@@ sim/tb_lru_key_value_cache_unit.sv @@
module tb_lru_key_value_cache_unit;
	import lrukv_pkg::*;

	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 85;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int               mismatches;
	int               pending;
	bit               quiet;
	bit               hold_req;

	// capacity and key pool size per random phase
	int phase_cap [PHASES]  = '{1, 0, 4, 31, 2, 16, 8, 3, 12, 5};
	int phase_keys [PHASES] = '{3, 2, 7, 20, 5, 20, 11, 5, 15, 8};
	logic signed [KEY_W-1:0] key_pool [$];

	lrukv_req_if req_ch();
	lrukv_rsp_if rsp_ch();

	lru_key_value_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	lru_cache_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatches),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

	// offer one access and hold it until the transfer
	task automatic issue_access(input op_t op, input logic signed [KEY_W-1:0] key,
			input logic signed [VAL_W-1:0] value);
		if (!quiet && $urandom_range(99) < 31) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.lookup_key <= key;
		req_ch.write_value <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_wdata <= cap;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop offering and let every result come back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side: random stalls, a quiet stretch and one long hold-off
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				rsp_ch.ready <= quiet || ($urandom_range(99) >= 31);
			end
		end
	end

	initial begin
		int p, n;
		op_t op;
		logic signed [KEY_W-1:0] key;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_GET;
		req_ch.lookup_key <= '0;
		req_ch.write_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of key and value, miss on empty store, overwrite
		issue_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
		issue_access(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
		issue_access(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
		issue_access(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		issue_access(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
		issue_access(OP_GET, 32'h8000_0000, 32'hffff_ffff);
		issue_access(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
		issue_access(OP_GET, 32'h0000_0000, 32'h1234_5678);
		issue_access(OP_GET, 32'hffff_ffff, 32'h0000_0000);
		issue_access(OP_PUT, 32'h7fff_ffff, 32'h1234_5678);
		issue_access(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
		issue_access(OP_GET, 32'h55aa_55aa, 32'h0000_0000);

		// capacity dropped below the entry count, then lru order under pressure
		wait_idle();
		write_capacity(2);
		issue_access(OP_PUT, 32'h0000_0011, 32'h0000_0101);
		issue_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
		issue_access(OP_PUT, 32'h0000_0022, 32'h0000_0202);
		issue_access(OP_GET, 32'h0000_0011, 32'h0000_0000);
		issue_access(OP_PUT, 32'h0000_0033, 32'h0000_0303);
		issue_access(OP_GET, 32'h0000_0022, 32'h0000_0000);
		issue_access(OP_GET, 32'h0000_0011, 32'h0000_0000);

		// random phases over a small key pool so hits and evictions are common
		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			write_capacity(phase_cap[p]);
			quiet = (p == 3);
			key_pool.delete();
			for (n = 0; n < phase_keys[p]; n++) key_pool.push_back($urandom);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 5 && n == 10) hold_req = 1'b1;
				op = $urandom_range(1) ? OP_PUT : OP_GET;
				if ($urandom_range(99) < 90)
					key = key_pool[$urandom_range(key_pool.size() - 1)];
				else
					key = $urandom;
				issue_access(op, key, $urandom);
			end
		end
		quiet = 1'b0;
		wait_idle();

		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
